/* rtl/sna_pkg.sv */
// ----------------------------------------------------------------------------
// sna_pkg: shared types and constants of the subnet address allocator
// Widths of the tree, item and result types, status and kind codes.
// ----------------------------------------------------------------------------
package sna_pkg;

	localparam int MAX_HOST_BITS = 8;
	localparam int ADDR_W        = 32;
	// heap node index: nodes 1 .. 2^(MAX_HOST_BITS+1)-1, leaves included
	localparam int NODE_W        = MAX_HOST_BITS + 1;
	localparam int NODE_DEPTH    = 1 << NODE_W;
	localparam int COUNT_W       = MAX_HOST_BITS + 1;
	localparam int HB_W          = $clog2(MAX_HOST_BITS + 1);
	localparam int PLEN_W        = 5;
	localparam int REG_IDX_W     = 1;

	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [NODE_W-1:0]        node_t;
	typedef logic [COUNT_W-1:0]       cnt_t;
	typedef logic [MAX_HOST_BITS-1:0] host_t;
	typedef logic [HB_W-1:0]          hbits_t;
	typedef logic [PLEN_W-1:0]        plen_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SUBNET_BASE   = 1'b0,
		REG_PREFIX_LENGTH = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_EXHAUSTED = 2'd1,
		STS_NOT_ALLOC = 2'd2,
		STS_RESERVED  = 2'd3
	} status_t;

	localparam plen_t PLEN_RESET = plen_t'(24);

	// decoded configuration
	typedef struct packed {
		addr_t base;
		addr_t hmask;     // host bits of an address
		node_t leaves;    // 2^H, heap index of host 0
		logic  one_host;  // H == 1: root is full at init
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		kind_t kind;
		host_t host;
		logic  in_net;
		logic  reserved;
		logic  want;      // allocate naming an address in the subnet
	} cmd_t;

	typedef struct packed {
		status_t status;
		addr_t   assigned;
		cnt_t    free_count;
	} res_t;

endpackage

/* rtl/sna_ram.sv */
// ----------------------------------------------------------------------------
// sna_ram: generic RAM
// One write port, one read port, registered read data, no reset of contents.
// ----------------------------------------------------------------------------
module sna_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/sna_front.sv */
// ----------------------------------------------------------------------------
// sna_front: item intake
// Classifies each accepted item against the subnet and queues it (2 deep).
// ----------------------------------------------------------------------------
module sna_front (
	input  logic          clk,
	input  logic          arst_n,
	input  sna_pkg::cfg_t cfg,
	input  logic          take,
	input  logic          kind,
	input  logic [31:0]   address,
	output logic          q_full,
	output logic          cmd_valid,
	output sna_pkg::cmd_t cmd,
	input  logic          cmd_pop
);

	sna_pkg::cmd_t cls;
	sna_pkg::cmd_t q_mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	sna_pkg::addr_t host_bits;

	always_comb begin
		host_bits    = address & cfg.hmask;
		cls.kind     = sna_pkg::kind_t'(kind);
		cls.host     = sna_pkg::host_t'(host_bits);
		cls.in_net   = ((address ^ cfg.base) & ~cfg.hmask) == '0;
		cls.reserved = (host_bits == '0) || (host_bits == cfg.hmask);
		cls.want     = (cls.kind == sna_pkg::KIND_ALLOC) && (address != '0) && cls.in_net;
	end

	assign q_full    = cnt_q[1];
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (take) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (take) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({take, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/sna_back.sv */
// ----------------------------------------------------------------------------
// sna_back: tree sequencer
// Owns the full-mark tree RAM, the free count and the clearing pass; runs
// lookup, descent and path update for one item at a time.
// ----------------------------------------------------------------------------
module sna_back (
	input  logic          clk,
	input  logic          arst_n,
	input  sna_pkg::cfg_t cfg,
	input  logic          init,
	output logic          clearing,
	input  logic          cmd_valid,
	input  sna_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output sna_pkg::res_t res
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_LEAF   = 7'b0000010,
		S_ROOT   = 7'b0000100,
		S_DESC   = 7'b0001000,
		S_UPRD   = 7'b0010000,
		S_UPCHK  = 7'b0100000,
		S_UPFREE = 7'b1000000
	} state_t;

	localparam sna_pkg::node_t ROOT = sna_pkg::node_t'(1);

	state_t         state_q, state_d;
	sna_pkg::node_t node_q, node_d;
	sna_pkg::cmd_t  item_q, item_d;
	sna_pkg::cnt_t  free_q, free_d;
	logic           clr_q;
	sna_pkg::node_t clr_cnt_q;

	logic           ram_we;
	sna_pkg::node_t ram_waddr;
	logic [0:0]     ram_wdata;
	sna_pkg::node_t ram_raddr;
	logic [0:0]     ram_rdata;

	sna_pkg::node_t leaf_in, leaf_q, last_leaf, chosen;
	logic           clr_val;

	sna_ram #(
		.WIDTH (1),
		.DEPTH (sna_pkg::NODE_DEPTH)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign clearing  = clr_q;
	assign leaf_in   = cfg.leaves | sna_pkg::node_t'(cmd.host);
	assign leaf_q    = cfg.leaves | sna_pkg::node_t'(item_q.host);
	assign last_leaf = sna_pkg::node_t'({cfg.leaves, 1'b0} - 1'b1);
	assign chosen    = ram_rdata[0] ? (node_q | ROOT) : node_q;
	// reserved hosts are taken; with a single host bit both leaves are, so the root is full
	assign clr_val   = (clr_cnt_q == cfg.leaves) || (clr_cnt_q == last_leaf) ||
	                   (cfg.one_host && (clr_cnt_q == ROOT));

	always_comb begin
		state_d      = state_q;
		node_d       = node_q;
		item_d       = item_q;
		free_d       = free_q;
		cmd_pop      = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = node_q;
		ram_wdata    = 1'b0;
		ram_raddr    = node_q;
		res_push     = 1'b0;
		res.status   = sna_pkg::STS_OK;
		res.assigned = '0;
		res.free_count = free_q;

		unique case (state_q)
			S_IDLE: begin
				if (!clr_q && cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					item_d  = cmd;
					if (cmd.kind == sna_pkg::KIND_ALLOC) begin
						if (cmd.want) begin
							ram_raddr = leaf_in;
							state_d   = S_LEAF;
						end else begin
							ram_raddr = ROOT;
							state_d   = S_ROOT;
						end
					end else if (!cmd.in_net) begin
						res_push   = 1'b1;
						res.status = sna_pkg::STS_NOT_ALLOC;
					end else if (cmd.reserved) begin
						res_push   = 1'b1;
						res.status = sna_pkg::STS_RESERVED;
					end else begin
						ram_raddr = leaf_in;
						state_d   = S_LEAF;
					end
				end
			end
			S_LEAF: begin
				// read data is the taken mark of the named host
				if (item_q.kind == sna_pkg::KIND_ALLOC) begin
					if (!ram_rdata[0]) begin
						ram_we         = 1'b1;
						ram_waddr      = leaf_q;
						ram_wdata      = 1'b1;
						node_d         = leaf_q;
						free_d         = free_q - 1'b1;
						res_push       = 1'b1;
						res.assigned   = cfg.base | sna_pkg::addr_t'(item_q.host);
						res.free_count = free_d;
						state_d        = S_UPRD;
					end else begin
						ram_raddr = ROOT;
						state_d   = S_ROOT;
					end
				end else begin
					if (!ram_rdata[0]) begin
						res_push   = 1'b1;
						res.status = sna_pkg::STS_NOT_ALLOC;
						state_d    = S_IDLE;
					end else begin
						ram_we         = 1'b1;
						ram_waddr      = leaf_q;
						ram_wdata      = 1'b0;
						node_d         = leaf_q;
						free_d         = free_q + 1'b1;
						res_push       = 1'b1;
						res.free_count = free_d;
						state_d        = S_UPFREE;
					end
				end
			end
			S_ROOT: begin
				if (ram_rdata[0]) begin
					res_push   = 1'b1;
					res.status = sna_pkg::STS_EXHAUSTED;
					state_d    = S_IDLE;
				end else begin
					node_d    = sna_pkg::node_t'(2);
					ram_raddr = sna_pkg::node_t'(2);
					state_d   = S_DESC;
				end
			end
			S_DESC: begin
				// node_q is the left child just read; step right if it is full
				if (chosen >= cfg.leaves) begin
					ram_we         = 1'b1;
					ram_waddr      = chosen;
					ram_wdata      = 1'b1;
					node_d         = chosen;
					free_d         = free_q - 1'b1;
					res_push       = 1'b1;
					res.assigned   = cfg.base | sna_pkg::addr_t'(chosen ^ cfg.leaves);
					res.free_count = free_d;
					state_d        = S_UPRD;
				end else begin
					node_d    = sna_pkg::node_t'({chosen, 1'b0});
					ram_raddr = sna_pkg::node_t'({chosen, 1'b0});
				end
			end
			S_UPRD: begin
				// node_q just became full: look at its sibling
				if (node_q == ROOT) begin
					state_d = S_IDLE;
				end else begin
					ram_raddr = node_q ^ ROOT;
					state_d   = S_UPCHK;
				end
			end
			S_UPCHK: begin
				if (ram_rdata[0]) begin
					ram_we    = 1'b1;
					ram_waddr = node_q >> 1;
					ram_wdata = 1'b1;
					node_d    = node_q >> 1;
					state_d   = S_UPRD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_UPFREE: begin
				// a freed host clears every mark on its path
				if (node_q == ROOT) begin
					state_d = S_IDLE;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = node_q >> 1;
					ram_wdata = 1'b0;
					node_d    = node_q >> 1;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = clr_val;
			free_d    = sna_pkg::cnt_t'(cfg.leaves - 2'd2);
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		node_q <= node_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			free_q    <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			state_q <= init ? S_IDLE : state_d;
			free_q  <= free_d;
			if (init) begin
				clr_q     <= 1'b1;
				clr_cnt_q <= '0;
			end else if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == '1) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/sna_resq.sv */
// ----------------------------------------------------------------------------
// sna_resq: result queue
// Two-entry queue of finished results facing the output side.
// ----------------------------------------------------------------------------
module sna_resq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sna_pkg::res_t din,
	output logic          full,
	output logic          empty,
	input  logic          pop,
	output sna_pkg::res_t dout
);

	sna_pkg::res_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          take;

	assign full  = cnt_q[1];
	assign empty = cnt_q == 2'd0;
	assign dout  = mem_q[rd_ptr_q];
	assign take  = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/subnet_address_allocator_core.sv */
// ----------------------------------------------------------------------------
// subnet_address_allocator_core: host address allocator for one subnet
// Binary tree of full marks over the host numbers, queue ports on both sides.
// ----------------------------------------------------------------------------
// Usage: push an item (kind 0 allocate, kind 1 free) with an address; one
// result item per input item comes out in order with a status, the handed-out
// address (subnet_base OR host, 0 when nothing was handed out) and the number
// of free hosts left. After reset and after every configuration write the
// block runs a clearing pass over the whole tree RAM, holding full high; the
// hosts all-zero and all-ones start reserved. Items are processed one at a
// time by a sequencer around a single tree RAM with one read port and
// registered read data: a free outside the subnet or of a reserved host is
// answered at once, a free of a host not handed out after a leaf read, a free
// that releases a host clears the marks on its path; an allocate of the named
// address reads its leaf and falls back to a search of the lowest free host
// if it is taken, then marks full parents up its path. A 2-entry input queue
// and a 2-entry result queue let either side stall without stopping the other.
// ----------------------------------------------------------------------------
module subnet_address_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [31:0] address,
	// result items
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [31:0] assigned_address,
	output logic [8:0]  free_count,
	// configuration
	input  logic        wr_en,
	input  logic [0:0]  wr_index,
	input  logic [31:0] wr_data
);

	sna_pkg::addr_t  base_q;
	sna_pkg::plen_t  plen_q;
	sna_pkg::hbits_t hbits;
	sna_pkg::cfg_t   cfg;

	logic          front_full;
	logic          clearing;
	logic          take;
	logic          cmd_valid;
	logic          cmd_pop;
	sna_pkg::cmd_t cmd;
	logic          res_full;
	logic          res_push;
	sna_pkg::res_t res_in;
	sna_pkg::res_t res_out;

	// configuration registers; any write restarts the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			plen_q <= sna_pkg::PLEN_RESET;
		end else if (wr_en) begin
			unique case (sna_pkg::reg_idx_t'(wr_index))
				sna_pkg::REG_SUBNET_BASE:   base_q <= wr_data;
				sna_pkg::REG_PREFIX_LENGTH: plen_q <= wr_data[sna_pkg::PLEN_W-1:0];
				default:                    base_q <= base_q;
			endcase
		end
	end

	// host bits: 32 - prefix, saturated at the tree height
	always_comb begin
		if ({1'b0, plen_q} < 6'(sna_pkg::ADDR_W - sna_pkg::MAX_HOST_BITS)) begin
			hbits = sna_pkg::hbits_t'(sna_pkg::MAX_HOST_BITS);
		end else begin
			hbits = sna_pkg::hbits_t'(6'(sna_pkg::ADDR_W) - {1'b0, plen_q});
		end
		cfg.base     = base_q;
		cfg.leaves   = sna_pkg::node_t'(1) << hbits;
		cfg.hmask    = sna_pkg::addr_t'(cfg.leaves) - 1'b1;
		cfg.one_host = hbits == sna_pkg::hbits_t'(1);
	end

	assign full = front_full || clearing;
	assign take = push && !full;

	sna_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.take      (take),
		.kind      (kind),
		.address   (address),
		.q_full    (front_full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	sna_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.init      (wr_en),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	sna_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.empty  (empty),
		.pop    (pop),
		.dout   (res_out)
	);

	assign status           = res_out.status;
	assign assigned_address = res_out.assigned;
	assign free_count       = res_out.free_count;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the subnet address allocator core
// Feeds allocate and free items through the queue ports and tracks a
// behavioral host map of its own to predict every result item.
// Expected results are checked in order, field by field.
// The bench steps through several subnet settings, from one host bit to
// the saturated width, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sna_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int HOST_SLOTS     = 1 << MAX_HOST_BITS;
	// tail wait: covers the slowest item, a search, plus queue slack
	localparam int DRAIN_CYCLES   = 64;
	// the clearing pass is the longest legal quiet stretch
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		kind_t kind;
		addr_t addr;
	} request_t;

	// ------------------------------------------------------------------------
	// clock, reset, DUT ports
	// ------------------------------------------------------------------------
	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        push   = 1'b0;
	logic        kind   = 1'b0;
	logic [31:0] address = '0;
	logic        pop    = 1'b0;
	logic        wr_en  = 1'b0;
	logic [0:0]  wr_index = '0;
	logic [31:0] wr_data  = '0;
	logic        full;
	logic        empty;
	logic [1:0]  status;
	logic [31:0] assigned_address;
	logic [8:0]  free_count;

	always #(CLK_PERIOD / 2) clk = ~clk;

	subnet_address_allocator_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.kind             (kind),
		.address          (address),
		.empty            (empty),
		.pop              (pop),
		.status           (status),
		.assigned_address (assigned_address),
		.free_count       (free_count),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data)
	);

	// ------------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------------
	request_t    request_q[$];   // items waiting to be driven
	res_t        grant_q[$];     // predicted result items, oldest first
	int unsigned owed;           // items queued whose result has not come back
	bit          in_taken, out_taken;
	int unsigned in_gap, out_gap;
	int unsigned in_idle_pct, out_idle_pct;
	int unsigned idle_run;
	int unsigned errors, mismatches;
	int unsigned items_in, results_out, settings_run;
	int unsigned alloc_tally [4];
	int unsigned free_tally  [4];

	// ------------------------------------------------------------------------
	// host map of the allocator: one taken bit per host, full marks per
	// heap node (root at 1, leaves at 2^H + host)
	// ------------------------------------------------------------------------
	addr_t       net_base;
	plen_t       net_plen;
	bit          host_used   [HOST_SLOTS];
	bit          branch_full [HOST_SLOTS];
	int unsigned hosts_free;

	function automatic int unsigned host_width();
		int unsigned h;
		h = 32 - int'(net_plen);
		// short prefixes saturate at the tree depth
		if (h > MAX_HOST_BITS)
			h = MAX_HOST_BITS;
		return h;
	endfunction

	function automatic bit node_is_full(int unsigned c, int unsigned leaves);
		if (c >= leaves)
			return host_used[(c - leaves) & (HOST_SLOTS - 1)];
		return branch_full[c & (HOST_SLOTS - 1)];
	endfunction

	function automatic void refresh_path(int unsigned host, int unsigned leaves);
		int unsigned p;
		p = (leaves + host) >> 1;
		while (p >= 1) begin
			branch_full[p & (HOST_SLOTS - 1)] =
				node_is_full(2 * p, leaves) && node_is_full(2 * p + 1, leaves);
			p >>= 1;
		end
	endfunction

	// rebuild the map: only the all-zero and all-ones hosts are taken
	function automatic void clear_host_map();
		int unsigned leaves, n;
		leaves = 1 << host_width();
		foreach (host_used[i]) begin
			host_used[i]   = 1'b0;
			branch_full[i] = 1'b0;
		end
		host_used[0] = 1'b1;
		host_used[(leaves - 1) & (HOST_SLOTS - 1)] = 1'b1;
		for (n = leaves - 1; n >= 1; n--)
			branch_full[n] = node_is_full(2 * n, leaves) && node_is_full(2 * n + 1, leaves);
		hosts_free = leaves - 2;
	endfunction

	// one item against the map: returns the result item it must produce
	function automatic res_t serve_request(kind_t k, addr_t a);
		int unsigned leaves, host, n, c;
		addr_t       hmask;
		bit          in_net;
		res_t        r;
		leaves = 1 << host_width();
		hmask  = addr_t'(leaves - 1);
		host   = a & hmask;
		in_net = (a & ~hmask) == (net_base & ~hmask);
		r.status   = STS_OK;
		r.assigned = '0;
		if (k == KIND_ALLOC) begin
			if (a != '0 && in_net && !host_used[host]) begin
				host_used[host] = 1'b1;
			end else if (branch_full[1]) begin
				r.status = STS_EXHAUSTED;
			end else begin
				// descend, zero branch first whenever it has room
				n = 1;
				while (n < leaves) begin
					c = 2 * n;
					if (node_is_full(c, leaves))
						c++;
					n = c;
				end
				host = n - leaves;
				host_used[host & (HOST_SLOTS - 1)] = 1'b1;
			end
			if (r.status == STS_OK) begin
				refresh_path(host, leaves);
				hosts_free--;
				r.assigned = net_base | addr_t'(host);
			end
		end else begin
			if (!in_net)
				r.status = STS_NOT_ALLOC;
			else if (host == 0 || host == hmask)
				r.status = STS_RESERVED;
			else if (!host_used[host])
				r.status = STS_NOT_ALLOC;
			else begin
				host_used[host] = 1'b0;
				refresh_path(host, leaves);
				hosts_free++;
			end
		end
		r.free_count = cnt_t'(hosts_free);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// sampling at the rising edge: config writes, result check, prediction,
	// watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		res_t want;
		in_taken  = arst_n && push && !full;
		out_taken = arst_n && pop && !empty;

		// any write reloads the map
		if (arst_n && wr_en) begin
			if (reg_idx_t'(wr_index) == REG_SUBNET_BASE)
				net_base = wr_data;
			else
				net_plen = plen_t'(wr_data[PLEN_W-1:0]);
			clear_host_map();
		end

		// result side first: a result never belongs to an item taken this edge
		if (out_taken) begin
			results_out++;
			if (grant_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result item with nothing expected: status %0d addr %h free %0d",
						$realtime, status, assigned_address, free_count);
			end else begin
				want = grant_q.pop_front();
				owed--;
				if (status !== want.status || assigned_address !== want.assigned ||
						free_count !== want.free_count) begin
					errors++;
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"%0t: result %0d mismatch (exp/got): status %0d/%0d",
							" addr %h/%h free %0d/%0d"}, $realtime, results_out,
							want.status, status, want.assigned, assigned_address,
							want.free_count, free_count);
				end
			end
		end

		if (in_taken) begin
			items_in++;
			want = serve_request(kind_t'(kind), address);
			grant_q.push_back(want);
			if (kind_t'(kind) == KIND_ALLOC)
				alloc_tally[want.status]++;
			else
				free_tally[want.status]++;
		end

		// watchdog: cycles with no item moving on any port
		if (in_taken || out_taken || wr_en)
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no item moved for %0d cycles, %0d results owed",
				$realtime, idle_run, owed);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// item driver: falling edge, holds an item until it is taken, random gaps
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : item_driver
		request_t nxt;
		if (push && !in_taken) begin
			// item still waiting on full, keep it on the ports
		end else if (in_gap != 0) begin
			in_gap--;
			push <= 1'b0;
		end else if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			in_gap = $urandom_range(12);    // idle burst of random length
			push <= 1'b0;
		end else if (request_q.size() != 0) begin
			nxt = request_q.pop_front();
			push    <= 1'b1;
			kind    <= nxt.kind;
			address <= nxt.addr;
		end else begin
			push <= 1'b0;
		end
	end

	// result taker: pop stays high except for random stall bursts
	always @(negedge clk) begin : result_taker
		if (out_gap != 0) begin
			out_gap--;
			pop <= 1'b0;
		end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
			out_gap = $urandom_range(12);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// sequence helpers
	// ------------------------------------------------------------------------
	task automatic queue_request(kind_t k, addr_t a);
		request_t rq;
		rq.kind = k;
		rq.addr = a;
		owed++;
		request_q.push_back(rq);
	endtask

	// wait until every queued item has come back as a result
	task automatic wait_settled();
		while (owed != 0)
			@(negedge clk);
	endtask

	// register write, then ride out the clearing pass (full high, then low)
	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		while (!full)
			@(negedge clk);
		while (full)
			@(negedge clk);
	endtask

	// random item for a subnet: mostly in-net hosts or no-wish allocates so the map gets exercised,
	// some reserved hosts and some fully random addresses
	function automatic request_t draw_request(addr_t base, int unsigned hw,
			int unsigned alloc_pct);
		request_t    rq;
		addr_t       hmask, net;
		int unsigned pick;
		hmask = addr_t'((1 << hw) - 1);
		net   = base & ~hmask;
		pick  = $urandom_range(99);
		rq.kind = ($urandom_range(99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
		if (rq.kind == KIND_ALLOC && pick < 40)
			rq.addr = '0;                                  // no wish, lowest free host
		else if (pick < 75)
			rq.addr = net | (addr_t'($urandom()) & hmask);
		else if (pick < 85)
			rq.addr = net | (pick[0] ? hmask : '0);        // reserved host
		else
			rq.addr = $urandom();                          // mostly outside the subnet
		return rq;
	endfunction

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		int unsigned p, n, hw, leaves, i;
		addr_t       base;
		plen_t       plen;
		logic [31:0] plen_word;
		request_t    rq;

		net_base = '0;
		net_plen = PLEN_RESET;
		clear_host_map();
		in_idle_pct  = 10;
		out_idle_pct = 10;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// -- directed, reset setting: base 0, /24 -------------------------
		queue_request(KIND_ALLOC, 32'h0000_0000);   // no wish: host 1
		queue_request(KIND_ALLOC, 32'h0000_0005);   // free wish taken
		queue_request(KIND_ALLOC, 32'h0000_0005);   // wish already taken
		queue_request(KIND_ALLOC, 32'h0000_00FF);   // wish is the all-ones host
		queue_request(KIND_ALLOC, 32'hFFFF_FF10);   // wish outside the subnet
		queue_request(KIND_FREE,  32'h0000_0005);   // release
		queue_request(KIND_FREE,  32'h0000_0005);   // double release
		queue_request(KIND_FREE,  32'h0000_0077);   // never handed out
		queue_request(KIND_FREE,  32'h0000_0000);   // all-zero host
		queue_request(KIND_FREE,  32'h0000_00FF);   // all-ones host
		queue_request(KIND_FREE,  32'h1234_5601);   // outside the subnet
		queue_request(KIND_ALLOC, 32'hFFFF_FFFF);
		queue_request(KIND_ALLOC, 32'h0000_0080);
		queue_request(KIND_FREE,  32'h0000_0001);
		queue_request(KIND_FREE,  32'hFFFF_FFFF);
		wait_settled();
		settings_run++;

		// -- directed, /30 with host bits set in the base -------------------
		write_reg(REG_SUBNET_BASE, 32'hC0A8_0107);
		write_reg(REG_PREFIX_LENGTH, 32'd30);
		queue_request(KIND_ALLOC, 32'h0000_0000);   // host 1, base bits ORed in
		queue_request(KIND_ALLOC, 32'hC0A8_0106);   // host 2 by wish
		queue_request(KIND_ALLOC, 32'h0000_0000);   // pool exhausted
		queue_request(KIND_FREE,  32'hC0A8_0104);   // reserved
		queue_request(KIND_FREE,  32'hC0A8_0107);   // reserved
		queue_request(KIND_FREE,  32'hC0A8_0105);
		queue_request(KIND_ALLOC, 32'hC0A8_0104);   // wish is reserved host
		wait_settled();
		settings_run++;

		// -- directed, /31: one host bit, nothing to hand out ---------------
		write_reg(REG_PREFIX_LENGTH, 32'd31);
		write_reg(REG_SUBNET_BASE, 32'h0000_0000);
		queue_request(KIND_ALLOC, 32'h0000_0000);
		queue_request(KIND_FREE,  32'h0000_0001);
		queue_request(KIND_FREE,  32'h0000_0002);
		wait_settled();
		settings_run++;

		// -- random phases over several settings ----------------------------
		for (p = 0; p < 10; p++) begin
			case (p)
				0: plen = 5'd24;
				1: plen = 5'd30;
				2: plen = 5'd31;
				3: plen = 5'd0;    // far below the tree depth, saturates
				4: plen = 5'd28;
				5: plen = 5'd26;
				6: plen = 5'd25;
				7: plen = 5'd29;
				8: plen = 5'd27;
				default: plen = 5'd20;
			endcase
			case (p)
				1: base = '1;
				3: base = '0;
				default: base = $urandom();
			endcase
			// odd phases put junk above the prefix field of the write data
			plen_word = $urandom();
			if (p % 2 == 0)
				plen_word[31:PLEN_W] = '0;
			plen_word[PLEN_W-1:0] = plen;

			hw = 32 - int'(plen);
			if (hw > MAX_HOST_BITS)
				hw = MAX_HOST_BITS;
			leaves = 1 << hw;
			// enough allocate-heavy items to run the pool dry, then refill
			n = leaves + (leaves * 2) / 5 + 40;

			// idle profile for this phase; the last one runs flat out
			if (p == 9) begin
				in_idle_pct  = 0;
				out_idle_pct = 0;
			end else begin
				case ($urandom_range(2))
					0: in_idle_pct = 0;
					1: in_idle_pct = 8;
					default: in_idle_pct = 25;
				endcase
				case ($urandom_range(2))
					0: out_idle_pct = 0;
					1: out_idle_pct = 8;
					default: out_idle_pct = 25;
				endcase
			end

			if ($urandom_range(1)) begin
				write_reg(REG_SUBNET_BASE, base);
				write_reg(REG_PREFIX_LENGTH, plen_word);
			end else begin
				write_reg(REG_PREFIX_LENGTH, plen_word);
				write_reg(REG_SUBNET_BASE, base);
			end

			for (i = 0; i < n; i++) begin
				// halfway: hold the sender until the block has drained
				if (i == n / 2)
					wait_settled();
				rq = draw_request(base, hw, (i < (n * 3) / 4) ? 95 : 30);
				queue_request(rq.kind, rq.addr);
			end
			wait_settled();
			settings_run++;
		end

		// tail: let any late or stray result item show up
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (grant_q.size() != 0) begin
			errors += grant_q.size();
			$display("%0d expected result items never arrived", grant_q.size());
		end

		$display("Ran %0d items, %0d results, %0d settings (H from 1 to %0d bits)",
			items_in, results_out, settings_run, MAX_HOST_BITS);
		$display({"alloc ok/exhausted %0d/%0d, free ok/not-alloc/reserved %0d/%0d/%0d,",
			" %0d mismatches"}, alloc_tally[STS_OK], alloc_tally[STS_EXHAUSTED],
			free_tally[STS_OK], free_tally[STS_NOT_ALLOC], free_tally[STS_RESERVED],
			mismatches);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
rtl/sna_pkg.sv
rtl/sna_ram.sv
rtl/sna_front.sv
rtl/sna_back.sv
rtl/sna_resq.sv
rtl/subnet_address_allocator_core.sv
tb/tb_top.sv
